>>> rtl/core/hpst_pkg.sv
package hpst_pkg;

    // fixed field widths
    localparam int HEAD_BITS    = 13;
    localparam int ERR_BITS     = 13;
    localparam int DIFF_BITS    = 14;
    localparam int GAIN_BITS    = 16;
    localparam int OUT_BITS     = 8;

    // heading math width: covers 360 deg at the finest fraction plus a 13-bit input
    localparam int WIDE_BITS    = 20;

    // integral product is split into two 16x24 partial products
    localparam int SUM_EXT_BITS = 48;
    localparam int SUM_SPLIT    = 24;
    localparam int TOTAL_BITS   = 66;

    localparam int ERR_MAX      = 4095;
    localparam int ERR_MIN      = -4096;
    localparam int CORR_LIMIT   = 127;
    localparam int HALF_DEG     = 180;
    localparam int FULL_DEG     = 360;

    localparam int QUEUE_DEPTH  = 4;
    localparam int PTR_BITS     = 2;

    localparam int REG_IDX_BITS = 2;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic [GAIN_BITS-1:0] kp;
        logic [GAIN_BITS-1:0] ki;
        logic [GAIN_BITS-1:0] kd;
    } hpst_gains_t;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] diff;
        logic signed [ERR_BITS-1:0]  err;
    } hpst_item_t;

endpackage

>>> rtl/core/heading_pid_shortest_turn.sv
// Heading-correction PID with shortest-turn error.
//
// Input stream (s_*): one request carries a wanted and a current heading,
// 0..360 deg in 1/2^HEADING_FRAC_BITS degree. Each request gives exactly one
// result on the output stream (m_*): a clamped signed correction in m_tdata
// and a clamp flag in m_tuser.
// Config channel (cfg_*): gain_prop, gain_integ, gain_deriv at indexes 0..2,
// unsigned Q8.8; other indexes are dropped. cfg_ready is always high; write
// only while the block is drained.
//
// Throughput: one request per cycle. The front updates the error sum and the
// last error in the accept cycle, so that loop closes within the accept cycle.
// Path: queue write on the accepting edge, multiply, partial-sum add, final add,
// then shift/clamp into the output register that drives m_tvalid.
// A stall on m_tready backs up the back-end pipeline and then the 4-entry
// queue; s_tready drops only when the queue is full.
// Reset clears the gains, error sum, last error, queue and all stage valids.
module heading_pid_shortest_turn #(
    parameter int SUM_BITS          = 24,
    parameter int HEADING_FRAC_BITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,  // [12:0] wanted_heading, [25:13] current_heading
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [7:0] correction (signed)
    output logic [0:0]                          m_tuser,  // [0] clamped
    // gain writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hpst_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [hpst_pkg::GAIN_BITS-1:0]      cfg_data
);
    import hpst_pkg::*;

    localparam int Q_W = DIFF_BITS + ERR_BITS + SUM_BITS;

    hpst_gains_t gains_reg, gains_next;

    logic                       f_push, f_ready;
    hpst_item_t                 f_item;
    logic signed [SUM_BITS-1:0] f_sum;
    logic [Q_W-1:0]             q_out;
    logic                       q_valid, q_pop;
    hpst_item_t                 b_item;
    logic signed [SUM_BITS-1:0] b_sum;
    logic signed [OUT_BITS-1:0] corr;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        gains_next = gains_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:  gains_next.kp = cfg_data;
                REG_GAIN_INTEG: gains_next.ki = cfg_data;
                REG_GAIN_DERIV: gains_next.kd = cfg_data;
                default:        gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg <= '0;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    // front: wrap, shortest turn, error sum and difference
    hpst_front #(
        .SUM_BITS          (SUM_BITS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .wanted   (s_tdata[HEAD_BITS-1:0]),
        .current  (s_tdata[2*HEAD_BITS-1:HEAD_BITS]),
        .q_push   (f_push),
        .q_ready  (f_ready),
        .q_item   (f_item),
        .q_sum    (f_sum)
    );

    // decoupling queue
    hpst_fifo #(
        .DATA_W (Q_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .in_ready  (f_ready),
        .in_data   ({f_sum, f_item}),
        .out_valid (q_valid),
        .pop       (q_pop),
        .out_data  (q_out)
    );

    assign b_item = q_out[DIFF_BITS+ERR_BITS-1:0];
    assign b_sum  = q_out[Q_W-1:DIFF_BITS+ERR_BITS];

    // back: gain products, sum, shift and clamp
    hpst_back #(
        .SUM_BITS          (SUM_BITS),
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .gains      (gains_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (b_item),
        .q_sum      (b_sum),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .correction (corr),
        .clamped    (m_tuser[0])
    );

    assign m_tdata = corr;

endmodule

>>> rtl/core/hpst_front.sv
module hpst_front #(
    parameter int SUM_BITS          = 24,
    parameter int HEADING_FRAC_BITS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hpst_pkg::HEAD_BITS-1:0]    wanted,
    input  logic [hpst_pkg::HEAD_BITS-1:0]    current,
    output logic                              q_push,
    input  logic                              q_ready,
    output hpst_pkg::hpst_item_t              q_item,
    output logic signed [SUM_BITS-1:0]        q_sum
);
    import hpst_pkg::*;

    localparam logic signed [WIDE_BITS-1:0] HALF_TURN =
        WIDE_BITS'(HALF_DEG << HEADING_FRAC_BITS);
    localparam logic signed [WIDE_BITS-1:0] FULL_TURN =
        WIDE_BITS'(FULL_DEG << HEADING_FRAC_BITS);
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;
    logic signed [ERR_BITS-1:0]  last_reg, last_next;
    logic signed [WIDE_BITS-1:0] w_v, c_v, delta;
    logic signed [ERR_BITS-1:0]  err;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [SUM_BITS:0]    sum_ext;
    logic signed [SUM_BITS-1:0]  sum_sat;
    logic                        take;

    assign in_ready = q_ready;
    assign take     = in_valid && q_ready;

    always_comb
    begin
        w_v = {{(WIDE_BITS-HEAD_BITS){1'b0}}, wanted};
        c_v = {{(WIDE_BITS-HEAD_BITS){1'b0}}, current};
        if (w_v > HALF_TURN)
        begin
            w_v = w_v - FULL_TURN;
        end
        if (c_v > HALF_TURN)
        begin
            c_v = c_v - FULL_TURN;
        end
        // shorter turn: unwrap the negative side when the gap is a half turn or more
        if (w_v < 0 && c_v > 0)
        begin
            if (c_v - w_v >= HALF_TURN)
            begin
                w_v = w_v + FULL_TURN;
            end
        end
        else if (w_v > 0 && c_v < 0)
        begin
            if (w_v - c_v >= HALF_TURN)
            begin
                c_v = c_v + FULL_TURN;
            end
        end
        delta = w_v - c_v;
        priority if (delta > WIDE_BITS'(ERR_MAX))
        begin
            err = ERR_BITS'(ERR_MAX);
        end
        else if (delta < WIDE_BITS'(ERR_MIN))
        begin
            err = ERR_BITS'(ERR_MIN);
        end
        else
        begin
            err = delta[ERR_BITS-1:0];
        end
    end

    always_comb
    begin
        sum_ext = {sum_reg[SUM_BITS-1], sum_reg}
                + {{(SUM_BITS+1-ERR_BITS){err[ERR_BITS-1]}}, err};
        if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1])
        begin
            sum_sat = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_ext[SUM_BITS-1:0];
        end
        diff      = {err[ERR_BITS-1], err} - {last_reg[ERR_BITS-1], last_reg};
        sum_next  = take ? sum_sat : sum_reg;
        last_next = take ? err : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            last_reg <= '0;
        end
        else
        begin
            sum_reg  <= sum_next;
            last_reg <= last_next;
        end
    end

    assign q_push      = take;
    assign q_item.err  = err;
    assign q_item.diff = diff;
    assign q_sum       = sum_sat;

endmodule

>>> rtl/core/hpst_fifo.sv
module hpst_fifo #(
    parameter int DATA_W = 51
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              pop,
    output logic [DATA_W-1:0] out_data
);
    import hpst_pkg::*;

    logic [DATA_W-1:0]   mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   count_reg, count_next;

    assign in_ready  = count_reg != (PTR_BITS+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{PTR_BITS{1'b0}}, push} - {{PTR_BITS{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg == rd_ptr_reg + count_reg[PTR_BITS-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

>>> rtl/core/hpst_back.sv
module hpst_back #(
    parameter int SUM_BITS          = 24,
    parameter int HEADING_FRAC_BITS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  hpst_pkg::hpst_gains_t            gains,
    input  logic                             q_valid,
    output logic                             q_pop,
    input  hpst_pkg::hpst_item_t             q_item,
    input  logic signed [SUM_BITS-1:0]       q_sum,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [hpst_pkg::OUT_BITS-1:0] correction,
    output logic                             clamped
);
    import hpst_pkg::*;

    localparam int OUT_SHIFT = 8 + HEADING_FRAC_BITS;
    localparam int P_W   = GAIN_BITS + 1 + ERR_BITS;
    localparam int D_W   = GAIN_BITS + 1 + DIFF_BITS;
    localparam int LO_W  = GAIN_BITS + 1 + SUM_SPLIT + 1;
    localparam int HI_W  = GAIN_BITS + 1 + SUM_EXT_BITS - SUM_SPLIT;
    localparam int PD_W  = D_W + 1;

    logic signed [SUM_EXT_BITS-1:0] sum_x;
    logic signed [GAIN_BITS:0]      kp_s, ki_s, kd_s;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic adv1, adv2, adv3, advo;

    logic signed [P_W-1:0]        p_reg;
    logic signed [D_W-1:0]        dt_reg;
    logic signed [LO_W-1:0]       ilo_reg;
    logic signed [HI_W-1:0]       ihi_reg;
    logic signed [TOTAL_BITS-1:0] i_reg;
    logic signed [PD_W-1:0]       pd_reg;
    logic signed [TOTAL_BITS-1:0] total_reg;
    logic signed [TOTAL_BITS-1:0] raw;
    logic signed [OUT_BITS-1:0]   corr_reg, corr_next;
    logic                         clamp_reg, clamp_next;

    assign advo  = !vo_reg || out_ready;
    assign adv3  = !v3_reg || advo;
    assign adv2  = !v2_reg || adv3;
    assign adv1  = !v1_reg || adv2;
    assign q_pop = q_valid && adv1;

    assign sum_x = SUM_EXT_BITS'(q_sum);
    assign kp_s  = {1'b0, gains.kp};
    assign ki_s  = {1'b0, gains.ki};
    assign kd_s  = {1'b0, gains.kd};

    always_comb
    begin
        raw = total_reg >>> OUT_SHIFT;
        priority if (raw > TOTAL_BITS'(CORR_LIMIT))
        begin
            corr_next  = OUT_BITS'(CORR_LIMIT);
            clamp_next = 1'b1;
        end
        else if (raw < -TOTAL_BITS'(CORR_LIMIT))
        begin
            corr_next  = -OUT_BITS'(CORR_LIMIT);
            clamp_next = 1'b1;
        end
        else
        begin
            corr_next  = raw[OUT_BITS-1:0];
            clamp_next = 1'b0;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv1 && q_valid)
        begin
            p_reg   <= kp_s * q_item.err;
            dt_reg  <= kd_s * q_item.diff;
            ilo_reg <= ki_s * $signed({1'b0, sum_x[SUM_SPLIT-1:0]});
            ihi_reg <= ki_s * $signed(sum_x[SUM_EXT_BITS-1:SUM_SPLIT]);
        end
        if (adv2 && v1_reg)
        begin
            i_reg  <= (TOTAL_BITS'(ihi_reg) <<< SUM_SPLIT) + TOTAL_BITS'(ilo_reg);
            pd_reg <= PD_W'(p_reg) + PD_W'(dt_reg);
        end
        if (adv3 && v2_reg)
        begin
            total_reg <= i_reg + TOTAL_BITS'(pd_reg);
        end
        if (advo && v3_reg)
        begin
            corr_reg  <= corr_next;
            clamp_reg <= clamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= q_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (advo)
            begin
                vo_reg <= v3_reg;
            end
        end
    end

    assign out_valid  = vo_reg;
    assign correction = corr_reg;
    assign clamped    = clamp_reg;

`ifndef SYNTHESIS
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg && clamp_reg |->
            corr_reg == OUT_BITS'(CORR_LIMIT) || corr_reg == -OUT_BITS'(CORR_LIMIT))
        else $error("clamp flag without limit value");
    a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> corr_reg != {1'b1, {(OUT_BITS-1){1'b0}}})
        else $error("correction outside symmetric range");
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !advo |=> v3_reg && $stable(total_reg))
        else $error("stalled sum stage lost its value");
`endif

endmodule
